### rtl/core/sbsp_pkg.sv
package sbsp_pkg;

   localparam logic [7:0]  START_BYTE      = 8'hFF;
   localparam logic [7:0]  HEADER_BYTES    = 8'd3;
   localparam logic [7:0]  ERROR_INDEX     = 8'd2;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [15:0] TICK_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      FUNC_ARM  = 2'd0,
      FUNC_BYTE = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HUNT1   = 3'd1,
      PH_HUNT2   = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CHECKSUM = 2'd1,
      ST_NORESP   = 2'd2
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_FINAL   = 1'b1
   } kind_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] byte_value;
      logic [7:0] expected_params;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_index;
      logic [7:0] payload_byte;
      status_type status;
      logic [7:0] device_error;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
   } parse_stat_type;

endpackage

### rtl/core/sbsp_parse.sv
module sbsp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  sbsp_pkg::req_type      req,
   input  logic                   csr_we,
   input  logic [15:0]            csr_wdata,
   output sbsp_pkg::rsp_type      res,
   output sbsp_pkg::parse_stat_type stat
);
   import sbsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  err_ff, err_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] timeout_ff;

   logic [15:0] tick_inc;
   logic        timeout_hit;
   logic [8:0]  total_sum;
   logic [7:0]  count_inc;
   logic [7:0]  sum_inc;

   assign tick_inc    = (tick_ff != TICK_MAX) ? tick_ff + 16'd1 : tick_ff;
   assign timeout_hit = (tick_inc >= timeout_ff);
   assign total_sum   = {1'b0, req.expected_params} + {1'b0, HEADER_BYTES};
   assign count_inc   = count_ff + 8'd1;
   assign sum_inc     = sum_ff + req.byte_value;

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      total_in = total_ff;
      sum_in   = sum_ff;
      err_in   = err_ff;
      tick_in  = tick_ff;
      if (accept) begin
         case (req.func)
            FUNC_ARM: begin
               phase_in = PH_HUNT1;
               count_in = '0;
               total_in = total_sum[8] ? 8'hFF : total_sum[7:0];
               sum_in   = '0;
               err_in   = '0;
               tick_in  = '0;
            end
            FUNC_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  tick_in = tick_inc;
                  if (timeout_hit)
                     phase_in = PH_IDLE;
               end
            end
            FUNC_BYTE: begin
               unique case (phase_ff)
                  PH_IDLE: ;
                  PH_HUNT1: begin
                     if (req.byte_value == START_BYTE)
                        phase_in = PH_HUNT2;
                  end
                  PH_HUNT2: begin
                     phase_in = (req.byte_value == START_BYTE) ? PH_PAYLOAD : PH_HUNT1;
                  end
                  PH_PAYLOAD: begin
                     sum_in   = sum_inc;
                     count_in = count_inc;
                     if (count_ff == ERROR_INDEX)
                        err_in = req.byte_value;
                     if (count_inc >= total_ff)
                        phase_in = PH_CHECK;
                  end
                  PH_CHECK: phase_in = PH_IDLE;
                  default:  phase_in = PH_IDLE;
               endcase
            end
            default: ;
         endcase
      end
   end

   // outputs
   always_comb begin
      res            = '0;
      stat.res_valid = 1'b0;
      stat.busy      = (phase_ff != PH_IDLE);
      if (accept) begin
         case (req.func)
            FUNC_TICK: begin
               if (phase_ff != PH_IDLE && timeout_hit) begin
                  stat.res_valid = 1'b1;
                  res.kind       = KIND_FINAL;
                  res.status     = ST_NORESP;
               end
            end
            FUNC_BYTE: begin
               unique case (phase_ff)
                  PH_PAYLOAD: begin
                     stat.res_valid   = 1'b1;
                     res.kind         = KIND_PAYLOAD;
                     res.byte_index   = count_ff;
                     res.payload_byte = req.byte_value;
                  end
                  PH_CHECK: begin
                     stat.res_valid = 1'b1;
                     res.kind       = KIND_FINAL;
                     if (req.byte_value == ~sum_ff) begin
                        res.status       = ST_OK;
                        res.device_error = err_ff;
                     end else begin
                        res.status = ST_CHECKSUM;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         total_ff   <= '0;
         sum_ff     <= '0;
         err_ff     <= '0;
         tick_ff    <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         err_ff   <= err_in;
         tick_ff  <= tick_in;
         if (csr_we)
            timeout_ff <= csr_wdata;
      end
   end

endmodule

### rtl/core/sbsp_out_buf.sv
module sbsp_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbsp_pkg::rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbsp_pkg::rsp_type rsp_payload
);
   import sbsp_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    pop;

   assign pop         = main_valid_ff && rsp_ready;
   assign space       = !skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= push;
         main_ff       <= push_data;
      end else if (push) begin
         skid_ff       <= push_data;
         skid_valid_ff <= 1'b1;
      end
   end

endmodule

### rtl/core/servo_bus_status_packet_parser_top.sv
// A result is registered into the output buffer and is on rsp_valid once it sits in the head entry.
// Throughput: one request per cycle while req_ready is high; a two-entry output buffer holds results
// while rsp_ready is low, and req_ready drops only when both entries are full.
// Reset (synchronous): parser idle, counters and sums zero, timeout 1000 ticks,
// output buffer empty.
module servo_bus_status_packet_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbsp_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import sbsp_pkg::*;

   logic           accept;
   rsp_type        res;
   parse_stat_type stat;

   assign accept = req_valid && req_ready;

   sbsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .res       (res),
      .stat      (stat)
   );

   sbsp_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (stat.res_valid),
      .push_data   (res),
      .space       (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a full buffer always has its head entry valid
   a_skid_has_head: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("buffer second entry valid without head entry");

   // results only come from a running transaction
   a_res_when_busy: assert property (@(posedge clock) disable iff (reset)
      stat.res_valid |-> stat.busy)
      else $error("result produced while idle");

   // a final result closes the transaction
   a_final_idles: assert property (@(posedge clock) disable iff (reset)
      (stat.res_valid && res.kind == KIND_FINAL) |=> !stat.busy)
      else $error("parser still busy after final result");

   // an arm request never produces a result
   a_arm_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.func == FUNC_ARM) |-> !stat.res_valid)
      else $error("arm request produced a result");

endmodule
